// ===== hdl/ssd_pkg.sv =====
package ssd_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int CNT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  localparam logic [1:0] REQ_NUM  = 2'd0;
  localparam logic [1:0] REQ_RAW  = 2'd1;
  localparam logic [1:0] REQ_SCAN = 2'd2;

  localparam logic [7:0] SEG_DASH  = 8'h40;
  localparam logic [7:0] SEG_POINT = 8'h80;

  localparam logic [15:0] RECIP10 = 16'hCCCD;
  localparam int RECIP10_SHIFT = 19;

  typedef struct packed {
    logic start_num;
    logic step_num;
    logic write_raw;
    logic start_scan;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'h0: g = 8'h3F;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5B;
      4'h3: g = 8'h4F;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6D;
      4'h6: g = 8'h7D;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7F;
      4'h9: g = 8'h6F;
      4'hA: g = 8'h77;
      4'hB: g = 8'h7C;
      4'hC: g = 8'h39;
      4'hD: g = 8'h5E;
      4'hE: g = 8'h79;
      4'hF: g = 8'h71;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

// ===== hdl/ssd_ctrl.sv =====
module ssd_ctrl import ssd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  sts_t       sts,
  output cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NUM  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (req_type)
            REQ_NUM: begin
              cmd.start_num = 1'b1;
              state_next = S_NUM;
            end
            REQ_RAW: cmd.write_raw = 1'b1;
            REQ_SCAN: begin
              cmd.start_scan = 1'b1;
              state_next = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_NUM: begin
        cmd.step_num = 1'b1;
        if (sts.cnt_last) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.cnt_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ===== hdl/ssd_dp.sv =====
module ssd_dp import ssd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [15:0] value,
  input  logic       hex_mode,
  input  logic [2:0] point_position,
  input  logic [1:0] digit_index,
  input  logic [7:0] raw_segments,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] segment_drive,
  output logic [3:0] digit_select,
  output logic [1:0] scan_digit,
  output logic       last_digit
);

  logic [7:0]       patterns [DIGIT_COUNT];
  logic [15:0]      work;
  logic             hex;
  logic [2:0]       point;
  logic [CNT_W-1:0] cnt;

  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] quot10;
  logic [3:0]  rem;
  logic [3:0]  digit;
  logic [7:0]  num_pat;
  logic [31:0] cnt_ext;
  logic [3:0]  sel;

  // divide by ten through reciprocal, exact for 16-bit values
  assign prod    = {16'b0, work} * {16'b0, RECIP10};
  assign quot    = 16'(prod >> RECIP10_SHIFT);
  assign quot10  = (quot << 3) + (quot << 1);
  assign rem     = 4'(work - quot10);
  assign digit   = hex ? work[3:0] : rem;
  assign num_pat = glyph(digit) | ((32'(point) == 32'(cnt)) ? SEG_POINT : 8'h00);

  assign cnt_ext = 32'(cnt);
  assign sel     = (cnt_ext < 32'd4) ? ~(4'b0001 << cnt_ext[1:0]) : 4'hF;

  assign sts.cnt_last = (cnt_ext == 32'(DIGIT_COUNT - 1));
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.start_num) begin
      work  <= value;
      hex   <= hex_mode;
      point <= point_position;
    end else if (cmd.step_num) begin
      work <= hex ? (work >> 4) : quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start_num || cmd.start_scan) begin
      cnt <= '0;
    end else if ((cmd.step_num || cmd.load_out) && !sts.cnt_last) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGIT_COUNT; i++) patterns[i] <= SEG_DASH;
    end else begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (cmd.write_raw && (32'(digit_index) == 32'(i))) patterns[i] <= raw_segments;
        if (cmd.step_num && (cnt_ext == 32'(i))) patterns[i] <= num_pat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      segment_drive <= patterns[cnt];
      digit_select  <= sel;
      scan_digit    <= cnt_ext[1:0];
      last_digit    <= sts.cnt_last;
    end
  end

endmodule

// ===== hdl/seven_segment_scan_driver_top.sv =====
// number load: accepted, then converted one digit at a time for all 4 digits before the next item
// raw load: written while idle, so the next item is not held back
// scan: 4 results, one per cycle while the output is not stalled, chosen by the digit counter
// next item is taken once the last scan result sits in the output register
// reset: all digit patterns show a dash, output register empty
module seven_segment_scan_driver_top import ssd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [15:0] value,
  input  logic        hex_mode,
  input  logic [2:0]  point_position,
  input  logic [1:0]  digit_index,
  input  logic [7:0]  raw_segments,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  segment_drive,
  output logic [3:0]  digit_select,
  output logic [1:0]  scan_digit,
  output logic        last_digit
);

  cmd_t cmd;
  sts_t sts;

  ssd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .value          (value),
    .hex_mode       (hex_mode),
    .point_position (point_position),
    .digit_index    (digit_index),
    .raw_segments   (raw_segments),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .segment_drive  (segment_drive),
    .digit_select   (digit_select),
    .scan_digit     (scan_digit),
    .last_digit     (last_digit)
  );

`ifndef SYNTH
  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("output register not filled");

  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && req_type == REQ_SCAN) |=> in_stall)
    else $error("new item taken during scan");

  a_one_select: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(~digit_select))
    else $error("more than one digit selected");
`endif

endmodule
